### src/scs_pkg.sv
// Shared constants and types for the shadow call stack.
package scs_pkg;

   // Default sizes of the frame store.
   localparam int STACK_DEPTH_DEF = 256;
   localparam int ID_WIDTH_DEF    = 48;

   // Fixed field widths of the result item.
   localparam int CMD_WIDTH     = 2;
   localparam int OUTCOME_WIDTH = 3;
   localparam int DEPTH_OUT_W   = 9;
   localparam int COUNT_WIDTH   = 32;

   // Low ten bits of a desync counter; a wrap to zero raises the warning.
   localparam logic [COUNT_WIDTH-1:0] LOW_TEN_MASK = 32'h0000_03FF;

   // Command codes of an input item.
   localparam logic [CMD_WIDTH-1:0] CMD_ENTER = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_LEAVE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_TAIL  = 2'd2;

   // Outcome codes of a result item.
   typedef enum logic [OUTCOME_WIDTH-1:0] {
      OUT_PUSHED    = 3'd0,
      OUT_POPPED    = 3'd1,
      OUT_REPAIRED  = 3'd2,
      OUT_NOT_FOUND = 3'd3,
      OUT_EMPTY     = 3'd4,
      OUT_OVERFLOW  = 3'd5,
      OUT_TAILCALL  = 3'd6
   } outcome_type;

endpackage

### src/shadow_call_stack_resync_core.sv
// Shadow call stack for one thread: frames live in one RAM with a registered
// read. The result of an enter, a tail call, an ignored item or an overflow
// is loaded into the output register at the edge that accepts it. A leave
// reads the top frame from the RAM into the read register; when the top
// matches, the result goes to the output register once that is free;
// otherwise the search walks down one frame per cycle through the same read
// port until a frame matches or the bottom frame has missed. Only one item
// is in work at a time. A new item is taken while the previous result is
// being taken in the same cycle. Counters and depth are cleared by reset; the
// frame store needs no clearing since only frames below the depth are read.
module shadow_call_stack_resync_core #(
   parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF,
   parameter int ID_WIDTH    = scs_pkg::ID_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [scs_pkg::CMD_WIDTH-1:0]       req_command,
   input  logic [ID_WIDTH-1:0]                 req_function_id,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [scs_pkg::OUTCOME_WIDTH-1:0]   rsp_outcome,
   output logic [scs_pkg::DEPTH_OUT_W-1:0]     rsp_stack_depth,
   output logic [scs_pkg::COUNT_WIDTH-1:0]     rsp_repaired_count,
   output logic [scs_pkg::COUNT_WIDTH-1:0]     rsp_not_found_count,
   output logic [scs_pkg::COUNT_WIDTH-1:0]     rsp_tailcall_count,
   output logic                                rsp_desync_warning
);

   import scs_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int XW = (DW > DEPTH_OUT_W) ? DW : DEPTH_OUT_W;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_CHECK = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic                    first_ff, first_in;
   logic [ID_WIDTH-1:0]     id_ff, id_in;
   logic [COUNT_WIDTH-1:0]  rep_cnt_ff, rep_cnt_in;
   logic [COUNT_WIDTH-1:0]  miss_cnt_ff, miss_cnt_in;
   logic [COUNT_WIDTH-1:0]  tail_cnt_ff, tail_cnt_in;
   logic                    out_valid_ff, out_valid_in;
   outcome_type             outcome_ff, outcome_in;
   logic                    warn_ff, warn_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [ID_WIDTH-1:0]     rd_data;
   logic                    slot_free;
   logic                    accept;
   logic [COUNT_WIDTH-1:0]  rep_inc;
   logic [COUNT_WIDTH-1:0]  miss_inc;
   logic [XW-1:0]           depth_wide;

   // Frame store.
   scs_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_frames (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_function_id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The output register is free when empty or when its item leaves now.
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   assign rep_inc  = rep_cnt_ff + 1'b1;
   assign miss_inc = miss_cnt_ff + 1'b1;

   // Command decode and the downward search over the frame store.
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      pos_in       = pos_ff;
      first_in     = first_ff;
      id_in        = id_ff;
      rep_cnt_in   = rep_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      tail_cnt_in  = tail_cnt_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      outcome_in   = outcome_ff;
      warn_in      = warn_ff;
      wr_en        = 1'b0;
      wr_addr      = depth_ff[AW-1:0];
      rd_en        = 1'b0;
      rd_addr      = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in        = req_function_id;
               out_valid_in = 1'b1;
               warn_in      = 1'b0;
               outcome_in   = OUT_EMPTY;
               unique case (req_command)
                  CMD_ENTER: begin
                     if (depth_ff < DW'(STACK_DEPTH)) begin
                        wr_en      = 1'b1;
                        depth_in   = depth_ff + 1'b1;
                        outcome_in = OUT_PUSHED;
                     end else begin
                        outcome_in = OUT_OVERFLOW;
                     end
                  end
                  CMD_LEAVE: begin
                     if (depth_ff != '0) begin
                        // Read the top frame; the result comes after the compare.
                        out_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = AW'(depth_ff - 1'b1);
                        pos_in       = AW'(depth_ff - 1'b1);
                        first_in     = 1'b1;
                        state_in     = ST_CHECK;
                     end
                  end
                  CMD_TAIL: begin
                     if (depth_ff != '0) begin
                        depth_in    = depth_ff - 1'b1;
                        tail_cnt_in = tail_cnt_ff + 1'b1;
                        outcome_in  = OUT_TAILCALL;
                     end
                  end
                  default: begin
                     outcome_in = OUT_EMPTY;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (rd_data == id_ff) begin
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  if (first_ff) begin
                     depth_in   = depth_ff - 1'b1;
                     outcome_in = OUT_POPPED;
                     warn_in    = 1'b0;
                  end else begin
                     // Truncate: the matching frame and all above it go away.
                     depth_in   = DW'(pos_ff);
                     rep_cnt_in = rep_inc;
                     outcome_in = OUT_REPAIRED;
                     warn_in    = (rep_inc & LOW_TEN_MASK) == '0;
                  end
               end
            end else if (pos_ff == '0) begin
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  miss_cnt_in  = miss_inc;
                  outcome_in   = OUT_NOT_FOUND;
                  warn_in      = (miss_inc & LOW_TEN_MASK) == '0;
               end
            end else begin
               // Step one frame down.
               rd_en    = 1'b1;
               rd_addr  = pos_ff - 1'b1;
               pos_in   = pos_ff - 1'b1;
               first_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         rep_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         tail_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rep_cnt_ff   <= rep_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         tail_cnt_ff  <= tail_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      first_ff   <= first_in;
      id_ff      <= id_in;
      outcome_ff <= outcome_in;
      warn_ff    <= warn_in;
   end

   // Result outputs; the depth is reported in its low nine bits.
   assign depth_wide          = XW'(depth_ff);
   assign rsp_valid           = out_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_stack_depth     = depth_wide[DEPTH_OUT_W-1:0];
   assign rsp_repaired_count  = rep_cnt_ff;
   assign rsp_not_found_count = miss_cnt_ff;
   assign rsp_tailcall_count  = tail_cnt_ff;
   assign rsp_desync_warning  = warn_ff;

endmodule

### src/scs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module scs_ram #(
   parameter int WIDTH = scs_pkg::ID_WIDTH_DEF,
   parameter int DEPTH = scs_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### src/scs_checker.sv
// Port-level assertions for the shadow call stack and their bind.
module scs_checker #(
   parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEF,
   parameter int ID_WIDTH    = scs_pkg::ID_WIDTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [scs_pkg::CMD_WIDTH-1:0]       req_command,
   input logic [ID_WIDTH-1:0]                 req_function_id,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [scs_pkg::OUTCOME_WIDTH-1:0]   rsp_outcome,
   input logic [scs_pkg::DEPTH_OUT_W-1:0]     rsp_stack_depth,
   input logic [scs_pkg::COUNT_WIDTH-1:0]     rsp_repaired_count,
   input logic [scs_pkg::COUNT_WIDTH-1:0]     rsp_not_found_count,
   input logic [scs_pkg::COUNT_WIDTH-1:0]     rsp_tailcall_count,
   input logic                                rsp_desync_warning
);

   import scs_pkg::*;

   localparam logic [DEPTH_OUT_W-1:0] FULL_DEPTH = DEPTH_OUT_W'(STACK_DEPTH);

   // A stalled item stays and keeps its outcome.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome))
      else $error("stalled result item changed");

   // The warning only comes with a desync outcome.
   a_warn_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_desync_warning |->
         rsp_outcome == OUT_REPAIRED || rsp_outcome == OUT_NOT_FOUND)
      else $error("desync warning on a non-desync outcome");

   // A warning on a repair means the repair counter just wrapped its low bits.
   a_warn_rep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_desync_warning && rsp_outcome == OUT_REPAIRED |->
         (rsp_repaired_count & LOW_TEN_MASK) == '0)
      else $error("repair warning without low-bit wrap");

   // A warning on a miss means the miss counter just wrapped its low bits.
   a_warn_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_desync_warning && rsp_outcome == OUT_NOT_FOUND |->
         (rsp_not_found_count & LOW_TEN_MASK) == '0)
      else $error("miss warning without low-bit wrap");

   // An overflow is only reported with a full stack.
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_OVERFLOW |-> rsp_stack_depth == FULL_DEPTH)
      else $error("overflow reported below full depth");

endmodule

bind shadow_call_stack_resync_core scs_checker #(
   .STACK_DEPTH (STACK_DEPTH),
   .ID_WIDTH    (ID_WIDTH)
) u_scs_checker (.*);

### dv/shadow_call_stack_resync_core_test.sv
// Self-checking testbench for the shadow call stack core with its own stack predictor.
`timescale 1ns / 1ps

module shadow_call_stack_resync_core_test;
   import scs_pkg::*;

   localparam int STACK_DEPTH = STACK_DEPTH_DEF;
   localparam int ID_W        = ID_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   // A leave that misses at full depth walks every frame.
   localparam int DRAIN_CYCLES = STACK_DEPTH + 40;
   localparam int IDLE_PCT     = 36;
   // Command code 3 has no meaning; the block treats it as a no-op.
   localparam logic [CMD_WIDTH-1:0] CMD_NOOP = 2'd3;

   typedef struct {
      outcome_type            outcome;
      logic [DEPTH_OUT_W-1:0] depth;
      logic [COUNT_WIDTH-1:0] repaired;
      logic [COUNT_WIDTH-1:0] missing;
      logic [COUNT_WIDTH-1:0] tailcalls;
      logic                   warn;
   } call_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_WIDTH-1:0]     req_command;
   logic [ID_W-1:0]          req_function_id;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [OUTCOME_WIDTH-1:0] rsp_outcome;
   logic [DEPTH_OUT_W-1:0]   rsp_stack_depth;
   logic [COUNT_WIDTH-1:0]   rsp_repaired_count;
   logic [COUNT_WIDTH-1:0]   rsp_not_found_count;
   logic [COUNT_WIDTH-1:0]   rsp_tailcall_count;
   logic                     rsp_desync_warning;

   // Predicted stack and counters.
   logic [ID_W-1:0]        frame_copy [STACK_DEPTH];
   int                     frame_depth;
   logic [COUNT_WIDTH-1:0] repaired_cnt;
   logic [COUNT_WIDTH-1:0] missing_cnt;
   logic [COUNT_WIDTH-1:0] tailcall_cnt;

   call_result_type expected_results [$];
   logic [ID_W-1:0] id_pool [12];
   int sender_idle_pct = IDLE_PCT;
   int receiver_stall_pct = IDLE_PCT;
   int hold_cycles = 0;
   int failures = 0;
   int items_sent = 0;
   int results_checked = 0;
   int warnings_seen = 0;
   int outcome_seen [8];
   int cycle_count = 0;

   shadow_call_stack_resync_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_function_id     (req_function_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_outcome         (rsp_outcome),
      .rsp_stack_depth     (rsp_stack_depth),
      .rsp_repaired_count  (rsp_repaired_count),
      .rsp_not_found_count (rsp_not_found_count),
      .rsp_tailcall_count  (rsp_tailcall_count),
      .rsp_desync_warning  (rsp_desync_warning)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("shadow_call_stack_resync_core_test NOT OK");
      $finish;
   end

   function automatic logic [ID_W-1:0] rand_id();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[ID_W-1:0];
   endfunction

   // Apply one call event to the predicted stack and return its result.
   function automatic call_result_type predict_call(input logic [CMD_WIDTH-1:0] cmd,
                                                    input logic [ID_W-1:0] fid);
      call_result_type r;
      int pos;
      r.outcome = OUT_EMPTY;
      r.warn = 1'b0;
      case (cmd)
         CMD_ENTER: begin
            if (frame_depth < STACK_DEPTH) begin
               frame_copy[frame_depth] = fid;
               frame_depth++;
               r.outcome = OUT_PUSHED;
            end else begin
               r.outcome = OUT_OVERFLOW;
            end
         end
         CMD_LEAVE: begin
            if (frame_depth != 0) begin
               if (frame_copy[frame_depth-1] == fid) begin
                  frame_depth--;
                  r.outcome = OUT_POPPED;
               end else begin
                  // Search down for the topmost frame below the top that matches.
                  pos = frame_depth - 2;
                  while (pos >= 0 && frame_copy[pos] != fid) pos--;
                  if (pos >= 0) begin
                     frame_depth = pos;
                     repaired_cnt++;
                     r.warn = ((repaired_cnt & LOW_TEN_MASK) == '0);
                     r.outcome = OUT_REPAIRED;
                  end else begin
                     missing_cnt++;
                     r.warn = ((missing_cnt & LOW_TEN_MASK) == '0);
                     r.outcome = OUT_NOT_FOUND;
                  end
               end
            end
         end
         CMD_TAIL: begin
            if (frame_depth != 0) begin
               frame_depth--;
               tailcall_cnt++;
               r.outcome = OUT_TAILCALL;
            end
         end
         default: ;
      endcase
      r.depth = DEPTH_OUT_W'(frame_depth);
      r.repaired = repaired_cnt;
      r.missing = missing_cnt;
      r.tailcalls = tailcall_cnt;
      return r;
   endfunction

   // Offer one item, with random idle cycles ahead of it. Starts and ends at a falling edge.
   task automatic send_call(input logic [CMD_WIDTH-1:0] cmd, input logic [ID_W-1:0] fid);
      call_result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_command <= CMD_WIDTH'($urandom_range(3));
         req_function_id <= rand_id();
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_function_id <= fid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_call(cmd, fid);
      items_sent++;
      @(negedge clock);
      expected_results.insert(expected_results.size(), r);
   endtask

   // Withdraw the offer and wait until every predicted result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested.
   initial begin : receiver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      call_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with no item pending, expected none, actual outcome %0d",
                     $time, rsp_outcome);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("outcome", 48'(want.outcome), 48'(rsp_outcome));
            check_field("stack_depth", 48'(want.depth), 48'(rsp_stack_depth));
            check_field("repaired_count", 48'(want.repaired), 48'(rsp_repaired_count));
            check_field("not_found_count", 48'(want.missing), 48'(rsp_not_found_count));
            check_field("tailcall_count", 48'(want.tailcalls), 48'(rsp_tailcall_count));
            check_field("desync_warning", 48'(want.warn), 48'(rsp_desync_warning));
            results_checked++;
            outcome_seen[rsp_outcome]++;
            if (rsp_desync_warning) warnings_seen++;
         end
      end
   end

   // Boundary values, every command and the special cases on a short stack.
   task automatic test_edge_calls();
      logic [ID_W-1:0] id_a;
      logic [ID_W-1:0] id_b;
      logic [ID_W-1:0] id_c;
      id_a = 48'hAAAA_5555_0001;
      id_b = 48'h5555_AAAA_FFFE;
      id_c = 48'h0000_0000_1234;
      // Leave, tail call and no-op on an empty stack are ignored.
      send_call(CMD_LEAVE, '0);
      send_call(CMD_TAIL, '1);
      send_call(CMD_NOOP, '0);
      // Extreme identifiers pushed and popped from the top.
      send_call(CMD_ENTER, '0);
      send_call(CMD_ENTER, '1);
      send_call(CMD_ENTER, id_c);
      send_call(CMD_LEAVE, id_c);
      send_call(CMD_LEAVE, '1);
      // Two frames match; the topmost one below the top is chosen.
      send_call(CMD_ENTER, id_a);
      send_call(CMD_ENTER, id_b);
      send_call(CMD_ENTER, id_a);
      send_call(CMD_ENTER, id_c);
      send_call(CMD_LEAVE, id_a);
      send_call(CMD_LEAVE, 48'hDEAD_BEEF_0BAD);
      send_call(CMD_NOOP, rand_id());
      send_call(CMD_TAIL, rand_id());
      // Match on the bottom frame truncates the stack to empty.
      send_call(CMD_LEAVE, '0);
      send_call(CMD_TAIL, '0);
      wait_drained();
   endtask

   // Fill the stack to the top under a long receiver hold-off, then overflow it.
   task automatic test_full_stack();
      logic [ID_W-1:0] fid;
      sender_idle_pct = 0;
      hold_cycles = 300;
      while (frame_depth < STACK_DEPTH) begin
         fid = rand_id();
         fid[ID_W-1] = 1'b0;
         send_call(CMD_ENTER, fid);
      end
      sender_idle_pct = IDLE_PCT;
      send_call(CMD_ENTER, rand_id());
      send_call(CMD_TAIL, '0);
      send_call(CMD_ENTER, '1);
      send_call(CMD_ENTER, '0);
      // A miss at full depth walks every frame.
      fid = rand_id();
      fid[ID_W-1] = 1'b1;
      send_call(CMD_LEAVE, fid);
      // The sender pauses until the stack has answered everything.
      wait_drained();
      send_call(CMD_LEAVE, frame_copy[0]);
      wait_drained();
   endtask

   // Mostly well-formed call traces with random content, plus stray leaves and no-ops.
   task automatic test_random_calls(input int count);
      int roll;
      int pos;
      logic [ID_W-1:0] fid;
      foreach (id_pool[i]) id_pool[i] = rand_id();
      for (int n = 0; n < count; n++) begin
         if (n == count * 3 / 8) begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         if (n == count * 5 / 8) begin
            sender_idle_pct = IDLE_PCT;
            receiver_stall_pct = IDLE_PCT;
         end
         fid = ($urandom_range(9) < 6) ? id_pool[$urandom_range(11)] : rand_id();
         roll = $urandom_range(99);
         // Deep stacks lean toward leaves so that most searches stay short.
         if (frame_depth > 40 && roll < 45) roll += 45;
         if (roll < 45) begin
            send_call(CMD_ENTER, fid);
         end else if (roll < 75 && frame_depth != 0) begin
            pos = ($urandom_range(3) != 0) ? frame_depth - 1 : $urandom_range(frame_depth - 1);
            send_call(CMD_LEAVE, frame_copy[pos]);
         end else if (roll < 85) begin
            send_call(CMD_LEAVE, fid);
         end else if (roll < 96) begin
            send_call(CMD_TAIL, fid);
         end else begin
            send_call(CMD_NOOP, fid);
         end
      end
      wait_drained();
   endtask

   initial begin : run_tests
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_ENTER;
      req_function_id = '0;
      frame_depth = 0;
      repaired_cnt = '0;
      missing_cnt = '0;
      tailcall_cnt = '0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_calls();
      test_full_stack();
      test_random_calls(130);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d results for %0d items: %0d pushes, %0d top pops, %0d repairs,",
               results_checked, items_sent, outcome_seen[OUT_PUSHED], outcome_seen[OUT_POPPED],
               outcome_seen[OUT_REPAIRED]);
      $display("%0d misses, %0d ignored, %0d overflows, %0d tail calls, %0d desync warnings.",
               outcome_seen[OUT_NOT_FOUND], outcome_seen[OUT_EMPTY],
               outcome_seen[OUT_OVERFLOW], outcome_seen[OUT_TAILCALL], warnings_seen);
      if (failures == 0) begin
         $display("shadow_call_stack_resync_core_test OK");
      end else begin
         $display("shadow_call_stack_resync_core_test NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
src/scs_pkg.sv
src/scs_ram.sv
src/shadow_call_stack_resync_core.sv
src/scs_checker.sv
dv/shadow_call_stack_resync_core_test.sv
